// ===== hw/rtl/soh_pkg.sv =====
// Shared constants and elaboration-time trig functions for the segment/box hit test.
// No dependencies; imported by the top level, the trig unit, the rotation unit and the slab unit.
`default_nettype none
package soh_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int TRIG_TABLE_BITS_DEF = 10;
    localparam int ANGLE_W             = 17;
    localparam int M_W                 = 16;
    localparam int ANGLE_TURN          = 46080;
    localparam longint HALF_PI_Q30     = 64'sd1686629713;
    localparam longint ONE_Q30         = 64'sd1 <<< 30;

    function automatic int trig_frac(input int cw);
        return ((61 - cw) < 30) ? (61 - cw) : 30;
    endfunction

    // Truncating quotient of a non-negative numerator by a positive divisor, worked
    // out by shift and subtract.
    function automatic longint div_pos(input longint n, input longint d);
        longint q;
        longint rem;
        q   = 0;
        rem = 0;
        for (int i = 62; i >= 0; i--) begin
            rem = (rem <<< 1) | ((n >>> i) & 64'sd1);
            q   = q <<< 1;
            if (rem >= d) begin
                rem = rem - d;
                q   = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Base sine (want_cos = 0) or cosine of quarter-wave entry r, in tf fraction bits.
    function automatic longint base_trig(input int r, input int tb, input int tf,
                                         input bit want_cos);
        longint x;
        longint ts;
        longint tc;
        longint s;
        longint c;
        longint qs;
        longint v;
        int     sh;
        qs = 64'sd1 <<< (tb - 2);
        x  = (longint'(r) * HALF_PI_Q30 + (qs >>> 1)) >>> (tb - 2);
        ts = x;
        s  = x;
        tc = ONE_Q30;
        c  = ONE_Q30;
        for (int k = 1; k <= 7; k++) begin
            ts = div_pos(((ts * x) >>> 30) * x >>> 30, longint'((2 * k) * (2 * k + 1)));
            tc = div_pos(((tc * x) >>> 30) * x >>> 30, longint'((2 * k - 1) * (2 * k)));
            s  = ((k & 1) == 1) ? s - ts : s + ts;
            c  = ((k & 1) == 1) ? c - tc : c + tc;
        end
        v = want_cos ? c : s;
        if (v < 0) v = 0;
        if (v > ONE_Q30) v = ONE_Q30;
        sh = 30 - tf;
        if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/soh_trig.sv =====
// Angle-to-table index conversion and quarter-wave sine/cosine lookup, two stages.
// Depends on soh_pkg for the table builder function.
`default_nettype none
module soh_trig #(
    parameter int TRIG_TABLE_BITS = soh_pkg::TRIG_TABLE_BITS_DEF,
    parameter int TRIG_FRAC       = soh_pkg::trig_frac(soh_pkg::COORD_WIDTH_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [soh_pkg::M_W-1:0]       i_m,
    output logic                          o_valid,
    output logic signed [TRIG_FRAC+1:0]   o_sin,
    output logic signed [TRIG_FRAC+1:0]   o_cos
);
    import soh_pkg::*;

    localparam int B   = TRIG_TABLE_BITS;
    localparam int QS  = 1 << (B - 2);
    localparam int TVW = TRIG_FRAC + 2;
    localparam int TW  = B + 6;
    localparam int RS  = B + 13;
    localparam int RKW = RS - 4;
    localparam int PRW = TW + RKW;
    localparam int HALF_TURN = ANGLE_TURN / 2;
    localparam longint RK = ((64'sd1 <<< RS) + 64'sd44) / 64'sd45;

    logic [M_W+B-1:0]  w_scaled;
    logic [TW-1:0]     w_t;
    logic [PRW-1:0]    w_prod;
    logic [B-1:0]      r_idx;
    logic              r_v1;
    logic              r_v2;
    logic signed [TVW-1:0] w_base_s [QS];
    logic signed [TVW-1:0] w_base_c [QS];
    logic signed [TVW-1:0] w_bs;
    logic signed [TVW-1:0] w_bc;
    logic signed [TVW-1:0] n_sin;
    logic signed [TVW-1:0] n_cos;
    logic signed [TVW-1:0] r_sin;
    logic signed [TVW-1:0] r_cos;

    // Index is floor((m * 2^B + half turn) / turn); the turn is 1024 * 45 and the
    // divide by 45 is an exact reciprocal multiply.
    assign w_scaled = {i_m, B'(0)} + (M_W + B)'(HALF_TURN);
    assign w_t      = TW'(w_scaled >> 10);
    assign w_prod   = PRW'(w_t) * PRW'(RK[RKW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= w_prod[RS+B-1:RS];
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    for (genvar g = 0; g < QS; g++) begin : g_tab
        localparam longint SV = base_trig(g, B, TRIG_FRAC, 1'b0);
        localparam longint CV = base_trig(g, B, TRIG_FRAC, 1'b1);
        assign w_base_s[g] = SV[TVW-1:0];
        assign w_base_c[g] = CV[TVW-1:0];
    end

    assign w_bs = w_base_s[r_idx[B-3:0]];
    assign w_bc = w_base_c[r_idx[B-3:0]];

    always_comb begin
        case (r_idx[B-1:B-2])
            2'd0: begin
                n_sin = w_bs;
                n_cos = w_bc;
            end
            2'd1: begin
                n_sin = w_bc;
                n_cos = -w_bs;
            end
            2'd2: begin
                n_sin = -w_bs;
                n_cos = -w_bc;
            end
            default: begin
                n_sin = -w_bc;
                n_cos = w_bs;
            end
        endcase
    end

    assign o_valid = r_v2;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;
endmodule
`default_nettype wire

// ===== hw/rtl/soh_rot.sv =====
// Rotation of both segment ends into the box frame: products, then sum and rounding.
// Depends on soh_pkg only for defaults.
`default_nettype none
module soh_rot #(
    parameter int COORD_WIDTH = soh_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC   = soh_pkg::trig_frac(soh_pkg::COORD_WIDTH_DEF)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [COORD_WIDTH:0]     i_ax,
    input  logic signed [COORD_WIDTH:0]     i_ay,
    input  logic signed [COORD_WIDTH:0]     i_bx,
    input  logic signed [COORD_WIDTH:0]     i_by,
    input  logic signed [TRIG_FRAC+1:0]     i_sin,
    input  logic signed [TRIG_FRAC+1:0]     i_cos,
    input  logic [COORD_WIDTH-2:0]          i_hw,
    input  logic [COORD_WIDTH-2:0]          i_hh,
    output logic                            o_valid,
    output logic signed [COORD_WIDTH+2:0]   o_px,
    output logic signed [COORD_WIDTH+2:0]   o_py,
    output logic signed [COORD_WIDTH+2:0]   o_ex,
    output logic signed [COORD_WIDTH+2:0]   o_ey,
    output logic [COORD_WIDTH-2:0]          o_hw,
    output logic [COORD_WIDTH-2:0]          o_hh
);
    import soh_pkg::*;

    localparam int MW = COORD_WIDTH + TRIG_FRAC + 3;
    localparam int SW = MW + 1;
    localparam int PW = COORD_WIDTH + 3;
    localparam logic signed [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (TRIG_FRAC - 1);

    logic signed [MW-1:0] r_axc, r_ays, r_ayc, r_axs;
    logic signed [MW-1:0] r_bxc, r_bys, r_byc, r_bxs;
    logic signed [SW-1:0] w_spx, w_spy, w_sex, w_sey;
    logic signed [PW-1:0] r_px, r_py, r_ex, r_ey;
    logic [COORD_WIDTH-2:0] r_hw1, r_hh1, r_hw2, r_hh2;
    logic r_v1;
    logic r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axc <= MW'(i_ax) * MW'(i_cos);
        r_ays <= MW'(i_ay) * MW'(i_sin);
        r_ayc <= MW'(i_ay) * MW'(i_cos);
        r_axs <= MW'(i_ax) * MW'(i_sin);
        r_bxc <= MW'(i_bx) * MW'(i_cos);
        r_bys <= MW'(i_by) * MW'(i_sin);
        r_byc <= MW'(i_by) * MW'(i_cos);
        r_bxs <= MW'(i_bx) * MW'(i_sin);
        r_hw1 <= i_hw;
        r_hh1 <= i_hh;
        r_px  <= w_spx[TRIG_FRAC+PW-1:TRIG_FRAC];
        r_py  <= w_spy[TRIG_FRAC+PW-1:TRIG_FRAC];
        r_ex  <= w_sex[TRIG_FRAC+PW-1:TRIG_FRAC];
        r_ey  <= w_sey[TRIG_FRAC+PW-1:TRIG_FRAC];
        r_hw2 <= r_hw1;
        r_hh2 <= r_hh1;
    end

    // Round half up, then take the arithmetic shift as a part-select.
    assign w_spx = SW'(r_axc) + SW'(r_ays) + RND;
    assign w_spy = SW'(r_ayc) - SW'(r_axs) + RND;
    assign w_sex = SW'(r_bxc) + SW'(r_bys) + RND;
    assign w_sey = SW'(r_byc) - SW'(r_bxs) + RND;

    assign o_valid = r_v2;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_ex    = r_ex;
    assign o_ey    = r_ey;
    assign o_hw    = r_hw2;
    assign o_hh    = r_hh2;
endmodule
`default_nettype wire

// ===== hw/rtl/soh_slab.sv =====
// Inside tests and exact slab test by cross-multiplied compares, four stages.
// Depends on soh_pkg only for defaults.
`default_nettype none
module soh_slab #(
    parameter int COORD_WIDTH = soh_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [COORD_WIDTH+2:0]   i_px,
    input  logic signed [COORD_WIDTH+2:0]   i_py,
    input  logic signed [COORD_WIDTH+2:0]   i_ex,
    input  logic signed [COORD_WIDTH+2:0]   i_ey,
    input  logic [COORD_WIDTH-2:0]          i_hw,
    input  logic [COORD_WIDTH-2:0]          i_hh,
    output logic                            o_valid,
    output logic                            o_hit
);
    import soh_pkg::*;

    localparam int HW  = COORD_WIDTH - 1;
    localparam int NW  = COORD_WIDTH + 4;
    localparam int LB  = NW / 2;
    localparam int HB  = NW - LB;
    localparam int LOW = NW + LB + 1;
    localparam int HIW = NW + HB + 1;
    localparam int PRW = 2 * NW + 1;

    typedef struct packed {
        logic in_any;
        logic par_x;
        logic par_y;
        logic ok_x;
        logic ok_y;
        logic pos_x;
        logic pos_y;
        logic lt_x;
        logic lt_y;
    } t_slab_flags;

    logic signed [NW-1:0] w_hx, w_hy, w_px, w_py, w_ex, w_ey, w_dx, w_dy;
    logic signed [NW-1:0] n_n1x, n_n2x, n_n1y, n_n2y;
    logic [NW-1:0]        n_ax, n_ay;
    t_slab_flags          n_f1, n_f2, r_f1, r_f2, r_f3;
    logic signed [NW-1:0] r_n1x, r_n2x, r_n1y, r_n2y;
    logic [NW-1:0]        r_ax, r_ay;
    logic signed [LOW-1:0] r_p1l, r_p2l, r_q1l, r_q2l;
    logic signed [HIW-1:0] r_p1h, r_p2h, r_q1h, r_q2h;
    logic signed [PRW-1:0] r_p1, r_p2, r_q1, r_q2;
    logic signed [LB:0]   w_axl, w_ayl;
    logic signed [HB:0]   w_axh, w_ayh;
    logic                 n_hit;
    logic                 r_hit;
    logic [3:0]           r_v;

    assign w_hx = $signed({{(NW-HW){1'b0}}, i_hw});
    assign w_hy = $signed({{(NW-HW){1'b0}}, i_hh});
    assign w_px = NW'(i_px);
    assign w_py = NW'(i_py);
    assign w_ex = NW'(i_ex);
    assign w_ey = NW'(i_ey);
    assign w_dx = w_ex - w_px;
    assign w_dy = w_ey - w_py;

    always_comb begin
        n_f1        = '0;
        n_f1.ok_x   = (w_px >= -w_hx) && (w_px <= w_hx);
        n_f1.ok_y   = (w_py >= -w_hy) && (w_py <= w_hy);
        n_f1.in_any = (n_f1.ok_x && n_f1.ok_y) ||
                      ((w_ex >= -w_hx) && (w_ex <= w_hx) &&
                       (w_ey >= -w_hy) && (w_ey <= w_hy));
        n_f1.par_x  = (w_dx == '0);
        n_f1.par_y  = (w_dy == '0);
        // Orient each axis so that the segment runs towards positive d.
        if (w_dx > 0) begin
            n_ax  = w_dx;
            n_n1x = -w_hx - w_px;
            n_n2x = w_hx - w_px;
        end else begin
            n_ax  = -w_dx;
            n_n1x = w_px - w_hx;
            n_n2x = w_px + w_hx;
        end
        if (w_dy > 0) begin
            n_ay  = w_dy;
            n_n1y = -w_hy - w_py;
            n_n2y = w_hy - w_py;
        end else begin
            n_ay  = -w_dy;
            n_n1y = w_py - w_hy;
            n_n2y = w_py + w_hy;
        end
    end

    assign w_axl = $signed({1'b0, r_ax[LB-1:0]});
    assign w_ayl = $signed({1'b0, r_ay[LB-1:0]});
    assign w_axh = $signed({1'b0, r_ax[NW-1:LB]});
    assign w_ayh = $signed({1'b0, r_ay[NW-1:LB]});

    always_comb begin
        n_f2       = r_f1;
        n_f2.pos_x = r_n1x > 0;
        n_f2.pos_y = r_n1y > 0;
        n_f2.lt_x  = r_n1x < $signed(r_ax);
        n_f2.lt_y  = r_n1y < $signed(r_ay);
    end

    // Entry of x against exit of y is p1 <= q2, entry of y against exit of x is q1 <= p2.
    always_comb begin
        if (r_f3.in_any) begin
            n_hit = 1'b1;
        end else if (r_f3.par_x && r_f3.par_y) begin
            n_hit = 1'b0;
        end else if (r_f3.par_y) begin
            n_hit = r_f3.ok_y && r_f3.pos_x && r_f3.lt_x;
        end else if (r_f3.par_x) begin
            n_hit = r_f3.ok_x && r_f3.pos_y && r_f3.lt_y;
        end else begin
            n_hit = (r_p1 <= r_q2) && (r_q1 <= r_p2) && (r_f3.pos_x || r_f3.pos_y) &&
                    r_f3.lt_x && r_f3.lt_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1  <= n_f1;
        r_n1x <= n_n1x;
        r_n2x <= n_n2x;
        r_n1y <= n_n1y;
        r_n2y <= n_n2y;
        r_ax  <= n_ax;
        r_ay  <= n_ay;
        r_f2  <= n_f2;
        r_p1l <= LOW'(r_n1x) * LOW'(w_ayl);
        r_p2l <= LOW'(r_n2x) * LOW'(w_ayl);
        r_q1l <= LOW'(r_n1y) * LOW'(w_axl);
        r_q2l <= LOW'(r_n2y) * LOW'(w_axl);
        r_p1h <= HIW'(r_n1x) * HIW'(w_ayh);
        r_p2h <= HIW'(r_n2x) * HIW'(w_ayh);
        r_q1h <= HIW'(r_n1y) * HIW'(w_axh);
        r_q2h <= HIW'(r_n2y) * HIW'(w_axh);
        r_f3  <= r_f2;
        r_p1  <= (PRW'(r_p1h) <<< LB) + PRW'(r_p1l);
        r_p2  <= (PRW'(r_p2h) <<< LB) + PRW'(r_p2l);
        r_q1  <= (PRW'(r_q1h) <<< LB) + PRW'(r_q1l);
        r_q2  <= (PRW'(r_q2h) <<< LB) + PRW'(r_q2l);
        r_hit <= n_hit;
    end

    assign o_valid = r_v[3];
    assign o_hit   = r_hit;
endmodule
`default_nettype wire

// ===== hw/rtl/segment_oriented_box_hit_test.sv =====
// Segment against oriented box hit test, fully pipelined.
// Stages in order: centring and angle reduction, trig index and lookup, rotation, then the slab test.
// Throughput: one transfer per clock; busy is always low and a query may enter every cycle.
// Results cannot be stalled; each shows for one cycle with o_done.
// Reset (synchronous, active low) clears the valid bits only; no query state survives it.
// Depends on soh_pkg, soh_trig, soh_rot and soh_slab.
`default_nettype none
module segment_oriented_box_hit_test #(
    parameter int COORD_WIDTH     = soh_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_TABLE_BITS = soh_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_WIDTH-1:0]        i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0]        i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0]        i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0]        i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0]        i_box_center_x,
    input  logic signed [COORD_WIDTH-1:0]        i_box_center_y,
    input  logic [COORD_WIDTH-2:0]               i_box_half_width,
    input  logic [COORD_WIDTH-2:0]               i_box_half_height,
    input  logic signed [soh_pkg::ANGLE_W-1:0]   i_box_angle,
    output logic                                 o_done,
    output logic                                 o_hit
);
    import soh_pkg::*;

    // The trig values carry as many fraction bits as keep each rotation product
    // within a 64-bit range for the chosen coordinate width.
    localparam int TF  = trig_frac(COORD_WIDTH);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = COORD_WIDTH + 3;
    localparam int AEW = ANGLE_W + 1;
    localparam int LAT = 9;
    localparam logic signed [AEW-1:0] TURN_S = AEW'(ANGLE_TURN);

    logic signed [DW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0] r_ax1, r_ay1, r_bx1, r_by1;
    logic signed [DW-1:0] r_ax2, r_ay2, r_bx2, r_by2;
    logic [COORD_WIDTH-2:0] r_hw, r_hh, r_hw1, r_hh1, r_hw2, r_hh2;
    logic [M_W-1:0]       r_m;
    logic [M_W-1:0]       n_m;
    logic signed [AEW-1:0] w_ang;
    logic signed [AEW-1:0] w_red;
    logic                 r_v;
    logic                 w_trig_v;
    logic signed [TF+1:0] w_sin, w_cos;
    logic                 w_rot_v;
    logic signed [PW-1:0] w_px, w_py, w_ex, w_ey;
    logic [COORD_WIDTH-2:0] w_hw, w_hh;

    // The block never pushes back: every cycle is a transfer slot.
    assign busy = 1'b0;

    // Reduce the angle into one turn. The input spans less than two turns either
    // side of zero, so a single add or subtract of one or two turns suffices.
    assign w_ang = AEW'(i_box_angle);
    always_comb begin
        if (w_ang >= TURN_S) begin
            w_red = w_ang - TURN_S;
        end else if (w_ang >= 0) begin
            w_red = w_ang;
        end else if (w_ang >= -TURN_S) begin
            w_red = w_ang + TURN_S;
        end else begin
            w_red = w_ang + (TURN_S <<< 1);
        end
        n_m = w_red[M_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= start && !busy;
        end
    end

    // First stage: centre the segment ends on the box. The differences then wait
    // alongside the two trig stages before rotation.
    always_ff @(posedge i_clk) begin
        r_ax  <= DW'(i_seg_start_x) - DW'(i_box_center_x);
        r_ay  <= DW'(i_seg_start_y) - DW'(i_box_center_y);
        r_bx  <= DW'(i_seg_end_x) - DW'(i_box_center_x);
        r_by  <= DW'(i_seg_end_y) - DW'(i_box_center_y);
        r_hw  <= i_box_half_width;
        r_hh  <= i_box_half_height;
        r_m   <= n_m;
        r_ax1 <= r_ax;
        r_ay1 <= r_ay;
        r_bx1 <= r_bx;
        r_by1 <= r_by;
        r_hw1 <= r_hw;
        r_hh1 <= r_hh;
        r_ax2 <= r_ax1;
        r_ay2 <= r_ay1;
        r_bx2 <= r_bx1;
        r_by2 <= r_by1;
        r_hw2 <= r_hw1;
        r_hh2 <= r_hh1;
    end

    soh_trig #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
        .TRIG_FRAC       (TF)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v),
        .i_m     (r_m),
        .o_valid (w_trig_v),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    soh_rot #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_FRAC   (TF)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_trig_v),
        .i_ax    (r_ax2),
        .i_ay    (r_ay2),
        .i_bx    (r_bx2),
        .i_by    (r_by2),
        .i_sin   (w_sin),
        .i_cos   (w_cos),
        .i_hw    (r_hw2),
        .i_hh    (r_hh2),
        .o_valid (w_rot_v),
        .o_px    (w_px),
        .o_py    (w_py),
        .o_ex    (w_ex),
        .o_ey    (w_ey),
        .o_hw    (w_hw),
        .o_hh    (w_hh)
    );

    soh_slab #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_slab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rot_v),
        .i_px    (w_px),
        .i_py    (w_py),
        .i_ex    (w_ex),
        .i_ey    (w_ey),
        .i_hw    (w_hw),
        .i_hh    (w_hh),
        .o_valid (o_done),
        .o_hit   (o_hit)
    );

    // Every result must trace back to a transfer exactly the pipeline depth earlier.
    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result strobe without a matching transfer");

    // The valid chain must be empty straight after a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");
endmodule
`default_nettype wire
